// File: rtl/core/pfd_pkg.sv
// shared types, constants, control store and saturation helpers for the filtered-derivative pid block
// no dependencies; used by pfd_seq, pfd_datapath and pid_filtered_derivative_top
package pfd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int STEP_W    = 3;

	// reset values of the derivative filter, tau = 0.1 and ts = 0.01
	localparam int unsigned ALPHA_RST = (10 * (1 << FRAC_BITS)) / 11;
	localparam int unsigned BETA_RST  = (200 * (1 << FRAC_BITS) + 11) / 22;

	// configuration register indexes
	localparam logic [2:0] REG_KP     = 3'd0;
	localparam logic [2:0] REG_KI_TS  = 3'd1;
	localparam logic [2:0] REG_KD     = 3'd2;
	localparam logic [2:0] REG_ALPHA  = 3'd3;
	localparam logic [2:0] REG_BETA   = 3'd4;
	localparam logic [2:0] REG_TRIM   = 3'd5;
	localparam logic [2:0] REG_SAT_HI = 3'd6;
	localparam logic [2:0] REG_SAT_LO = 3'd7;

	// limit flag codes
	localparam logic [1:0] HIT_NONE  = 2'd0;
	localparam logic [1:0] HIT_UPPER = 2'd1;
	localparam logic [1:0] HIT_LOWER = 2'd2;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_KI_E,
		MUL_ALPHA_LD,
		MUL_BETA_DIFF,
		MUL_KP_E,
		MUL_KD_DERIV
	} mul_sel_t;

	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_DIFF,
		ALU_INEW,
		ALU_DLOAD,
		ALU_DERIV,
		ALU_SUM3,
		ALU_ADD,
		ALU_FIN
	} alu_op_t;

	typedef struct packed {
		mul_sel_t mul;
		alu_op_t  alu;
		logic     wait_out;
		logic     last;
	} ucode_t;

	typedef struct packed {
		logic     go;
		mul_sel_t mul;
		alu_op_t  alu;
		logic     last;
	} ctrl_t;

	typedef struct packed {
		logic signed [31:0] kp;
		logic signed [31:0] ki_ts;
		logic signed [31:0] kd;
		logic [16:0]        alpha;
		logic [30:0]        beta;
		logic signed [31:0] trim;
		logic signed [31:0] sat_upper;
		logic signed [31:0] sat_lower;
	} cfg_t;

	// control store: one word per step
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		begin
			w = '{mul: MUL_NONE, alu: ALU_NOP, wait_out: 1'b0, last: 1'b1};
			case (step)
				3'd0: w = '{mul: MUL_KI_E,      alu: ALU_DIFF,  wait_out: 1'b0, last: 1'b0};
				3'd1: w = '{mul: MUL_ALPHA_LD,  alu: ALU_INEW,  wait_out: 1'b0, last: 1'b0};
				3'd2: w = '{mul: MUL_BETA_DIFF, alu: ALU_DLOAD, wait_out: 1'b0, last: 1'b0};
				3'd3: w = '{mul: MUL_KP_E,      alu: ALU_DERIV, wait_out: 1'b0, last: 1'b0};
				3'd4: w = '{mul: MUL_KD_DERIV,  alu: ALU_SUM3,  wait_out: 1'b0, last: 1'b0};
				3'd5: w = '{mul: MUL_NONE,      alu: ALU_ADD,   wait_out: 1'b0, last: 1'b0};
				3'd6: w = '{mul: MUL_NONE,      alu: ALU_FIN,   wait_out: 1'b1, last: 1'b1};
				default: w = '{mul: MUL_NONE,   alu: ALU_NOP,   wait_out: 1'b0, last: 1'b1};
			endcase
			return w;
		end
	endfunction

	// saturate a 35-bit signed sum to 32 bits
	function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
		logic signed [34:0] hi;
		logic signed [34:0] lo;
		begin
			hi = 35'sh0_7FFF_FFFF;
			lo = -35'sh0_8000_0000;
			if (v > hi)
				return 32'sh7FFF_FFFF;
			else if (v < lo)
				return 32'sh8000_0000;
			else
				return v[31:0];
		end
	endfunction

	// floor shift of the full product, then saturate to 32 bits
	function automatic logic signed [31:0] sat_prod(input logic signed [64:0] p);
		logic signed [64:0] sh;
		logic signed [64:0] hi;
		logic signed [64:0] lo;
		begin
			sh = p >>> FRAC_BITS;
			hi = 65'sd2147483647;
			lo = -65'sd2147483648;
			if (sh > hi)
				return 32'sh7FFF_FFFF;
			else if (sh < lo)
				return 32'sh8000_0000;
			else
				return sh[31:0];
		end
	endfunction

endpackage

// File: rtl/core/pid_filtered_derivative_top.sv
// top level of the pid controller with filtered derivative and anti-windup
// depends on pfd_pkg, pfd_seq and pfd_datapath
//
// usage:
//   s_* channel: one error sample per transfer; s_tdata[31:0] is the signed
//   fixed-point error, s_tuser[0] zeroes integral and history first
//   m_* channel: one result per input; m_tdata[31:0] is the clamped output,
//   m_tuser[1:0] flags the clamp (0 none, 1 upper, 2 lower)
//   cfg_we/cfg_index/cfg_wdata: register writes, taken on any edge with
//   cfg_we high; only write while no sample is in flight
// timing:
//   a sample takes one accept cycle plus seven microcode steps through a
//   single shared 33x32 multiplier, so m_tvalid rises 7 cycles after the
//   input transfer and a new sample is taken every 8 cycles
// reset:
//   arst_n clears the state, loads the register defaults and empties the
//   result register
// back-pressure:
//   the result sits in the output register until taken; the last step holds
//   while that register is full, and the input side stays closed meanwhile
module pid_filtered_derivative_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] error_in
	input  logic [0:0]  s_tuser,  // [0] clear_state
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] control_out
	output logic [1:0]  m_tuser,  // [1:0] limit_hit
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	pfd_pkg::cfg_t  cfg_q;
	pfd_pkg::ctrl_t ctrl;

	logic               busy;
	logic               accept;
	logic               out_free;
	logic               m_tvalid_q;
	logic signed [31:0] ctl_q;
	logic [1:0]         hit_q;
	logic signed [31:0] res_ctl;
	logic [1:0]         res_hit;

	// take a sample only while the sequencer is idle
	assign s_tready = ~busy;
	assign accept   = s_tvalid & s_tready;
	// result register can take a new value this cycle
	assign out_free = ~m_tvalid_q | m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp        <= '0;
			cfg_q.ki_ts     <= '0;
			cfg_q.kd        <= '0;
			cfg_q.alpha     <= 17'(pfd_pkg::ALPHA_RST);
			cfg_q.beta      <= 31'(pfd_pkg::BETA_RST);
			cfg_q.trim      <= '0;
			cfg_q.sat_upper <= 32'sh7FFF_FFFF;
			cfg_q.sat_lower <= 32'sh8000_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				pfd_pkg::REG_KP:     cfg_q.kp        <= cfg_wdata;
				pfd_pkg::REG_KI_TS:  cfg_q.ki_ts     <= cfg_wdata;
				pfd_pkg::REG_KD:     cfg_q.kd        <= cfg_wdata;
				pfd_pkg::REG_ALPHA:  cfg_q.alpha     <= cfg_wdata[16:0];
				pfd_pkg::REG_BETA:   cfg_q.beta      <= cfg_wdata[30:0];
				pfd_pkg::REG_TRIM:   cfg_q.trim      <= cfg_wdata;
				pfd_pkg::REG_SAT_HI: cfg_q.sat_upper <= cfg_wdata;
				pfd_pkg::REG_SAT_LO: cfg_q.sat_lower <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// step counter and control store
	pfd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_free (out_free),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	// arithmetic and controller state
	pfd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.error_in    (s_tdata),
		.clear_state (s_tuser[0]),
		.cfg         (cfg_q),
		.ctrl        (ctrl),
		.res_ctl     (res_ctl),
		.res_hit     (res_hit)
	);

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (ctrl.go && ctrl.last)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	// result register: payload, loaded on the final step
	always_ff @(posedge clk) begin
		if (ctrl.go && ctrl.last) begin
			ctl_q <= res_ctl;
			hit_q <= res_hit;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = ctl_q;
	assign m_tuser  = hit_q;

endmodule

// File: rtl/core/pfd_seq.sv
// microcode sequencer: step counter, control store lookup and wait-on-output jump
// depends on pfd_pkg
module pfd_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           out_free,
	output logic           busy,
	output pfd_pkg::ctrl_t ctrl
);

	logic                       busy_q;
	logic [pfd_pkg::STEP_W-1:0] step_q;
	pfd_pkg::ucode_t            word;
	logic                       stall;

	assign word  = pfd_pkg::ucode_rom(step_q);
	// conditional jump to self while the result register is still held
	assign stall = word.wait_out & ~out_free;
	assign busy  = busy_q;

	assign ctrl.go   = busy_q & ~stall;
	assign ctrl.mul  = word.mul;
	assign ctrl.alu  = word.alu;
	assign ctrl.last = word.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (!stall) begin
			if (word.last)
				busy_q <= 1'b0;
			else
				step_q <= step_q + 1'b1;
		end
	end

endmodule

// File: rtl/core/pfd_datapath.sv
// datapath: shared multiplier, saturating adder, controller state and output clamp
// depends on pfd_pkg; driven by control words from pfd_seq
module pfd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic signed [31:0] error_in,
	input  logic               clear_state,
	input  pfd_pkg::cfg_t      cfg,
	input  pfd_pkg::ctrl_t     ctrl,
	output logic signed [31:0] res_ctl,
	output logic [1:0]         res_hit
);

	logic signed [31:0] integral_q, last_error_q, last_deriv_q;
	logic signed [31:0] e_q, diff_q, inew_q, deriv_q;
	logic signed [34:0] acc_q;
	logic signed [64:0] prod_q;

	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] mul_p;
	logic signed [31:0] fm;
	logic signed [31:0] ctl0, ctl1;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul)
			pfd_pkg::MUL_KI_E: begin
				mul_a = {cfg.ki_ts[31], cfg.ki_ts};
				mul_b = e_q;
			end
			pfd_pkg::MUL_ALPHA_LD: begin
				mul_a = {16'b0, cfg.alpha};
				mul_b = last_deriv_q;
			end
			pfd_pkg::MUL_BETA_DIFF: begin
				mul_a = {2'b0, cfg.beta};
				mul_b = diff_q;
			end
			pfd_pkg::MUL_KP_E: begin
				mul_a = {cfg.kp[31], cfg.kp};
				mul_b = e_q;
			end
			pfd_pkg::MUL_KD_DERIV: begin
				mul_a = {cfg.kd[31], cfg.kd};
				mul_b = deriv_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign fm    = pfd_pkg::sat_prod(prod_q);

	// output clamp; lower limit checked last so it wins on crossed limits
	always_comb begin
		ctl0    = pfd_pkg::sat35(acc_q);
		ctl1    = ctl0;
		res_hit = pfd_pkg::HIT_NONE;
		if (ctl0 > cfg.sat_upper) begin
			ctl1    = cfg.sat_upper;
			res_hit = pfd_pkg::HIT_UPPER;
		end
		res_ctl = ctl1;
		if (ctl1 < cfg.sat_lower) begin
			res_ctl = cfg.sat_lower;
			res_hit = pfd_pkg::HIT_LOWER;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			last_error_q <= '0;
			last_deriv_q <= '0;
		end else if (load) begin
			if (clear_state) begin
				integral_q   <= '0;
				last_error_q <= '0;
				last_deriv_q <= '0;
			end
		end else if (ctrl.go && ctrl.alu == pfd_pkg::ALU_FIN) begin
			if (res_hit == pfd_pkg::HIT_NONE)
				integral_q <= inew_q;
			last_error_q <= e_q;
			last_deriv_q <= deriv_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (load)
			e_q <= error_in;
		if (ctrl.go) begin
			if (ctrl.mul != pfd_pkg::MUL_NONE)
				prod_q <= mul_p;
			case (ctrl.alu)
				pfd_pkg::ALU_DIFF:
					diff_q <= pfd_pkg::sat35(35'(e_q) - 35'(last_error_q));
				pfd_pkg::ALU_INEW:
					inew_q <= pfd_pkg::sat35(35'(integral_q) + 35'(fm));
				pfd_pkg::ALU_DLOAD:
					acc_q <= 35'(fm);
				pfd_pkg::ALU_DERIV:
					deriv_q <= pfd_pkg::sat35(acc_q + 35'(fm));
				pfd_pkg::ALU_SUM3:
					acc_q <= 35'(fm) + 35'(inew_q) + 35'(cfg.trim);
				pfd_pkg::ALU_ADD:
					acc_q <= acc_q + 35'(fm);
				default: ;
			endcase
		end
	end

endmodule
